>>> rtl/core/sha512_pkg.sv
// Package for the SHA-512/SHA-384 hash core.
// Holds round constants, initial values and the sigma functions; no dependencies.
package sha512_pkg;

	localparam int unsigned Rounds = 80;

	typedef logic [63:0] word_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic word_t iv_word(input logic mode, input logic [2:0] i);
		word_t r;
		r = '0;
		if (!mode) begin
			case (i)
				3'd0: r = 64'h6A09E667F3BCC908;
				3'd1: r = 64'hBB67AE8584CAA73B;
				3'd2: r = 64'h3C6EF372FE94F82B;
				3'd3: r = 64'hA54FF53A5F1D36F1;
				3'd4: r = 64'h510E527FADE682D1;
				3'd5: r = 64'h9B05688C2B3E6C1F;
				3'd6: r = 64'h1F83D9ABFB41BD6B;
				default: r = 64'h5BE0CD19137E2179;
			endcase
		end else begin
			case (i)
				3'd0: r = 64'hCBBB9D5DC1059ED8;
				3'd1: r = 64'h629A292A367CD507;
				3'd2: r = 64'h9159015A3070DD17;
				3'd3: r = 64'h152FECD8F70E5939;
				3'd4: r = 64'h67332667FFC00B31;
				3'd5: r = 64'h8EB44A8768581511;
				3'd6: r = 64'hDB0C2E0D64F98FA7;
				default: r = 64'h47B5481DBEFA4FA4;
			endcase
		end
		return r;
	endfunction

	localparam word_t RoundConst [Rounds] = '{
		64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
		64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
		64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
		64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
		64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
		64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
		64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
		64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
		64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
		64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
		64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
		64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
		64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
		64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
		64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
		64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
		64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
		64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
		64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
		64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
	};

	typedef struct packed {
		logic start;
		logic busy;
	} rnd_ctl_t;

endpackage

>>> rtl/core/sha512_round.sv
// One shared SHA-512 round unit with its message schedule window and working variables.
// Depends on sha512_pkg. One round per cycle; chain words are supplied by the caller.
module sha512_round (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      wr_en,
	input  logic [3:0]                wr_idx,
	input  sha512_pkg::word_t         wr_data,
	input  sha512_pkg::word_t         chain [8],
	output sha512_pkg::word_t         work [8],
	output sha512_pkg::rnd_ctl_t      ctl,
	output logic                      done
);
	import sha512_pkg::*;

	word_t     w_q [16];
	word_t     v_q [8];
	logic [6:0] t_q;
	logic      busy_q;
	logic      done_q;
	logic [3:0] t4;
	word_t     sched;
	word_t     w;
	word_t     t1;
	word_t     t2;

	assign t4 = t_q[3:0];
	assign sched = w_q[t4] + small_sigma1(w_q[t4 - 4'd2]) + w_q[t4 - 4'd7]
		+ small_sigma0(w_q[t4 - 4'd15]);
	assign w = (t_q >= 7'd16) ? sched : w_q[t4];
	assign t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ RoundConst[t_q] + w;
	assign t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			w_q[wr_idx] <= wr_data;
		end else if (busy_q) begin
			w_q[t4] <= w;
		end
		if (start) begin
			v_q <= chain;
		end else if (busy_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				t_q <= '0;
			end else if (busy_q) begin
				if (t_q == 7'(Rounds - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					t_q <= '0;
				end else begin
					t_q <= t_q + 7'd1;
				end
			end
		end
	end

	assign work = v_q;
	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign done = done_q;
endmodule

>>> rtl/core/sha512_sha384_hash_core.sv
// SHA-512 / SHA-384 hash core top level: sequencer, padding, chaining words and output.
// Depends on sha512_pkg and sha512_round.
// A non-final word leaves the input ready unless it completes a block (start, rounds, fold).
// A final word needs one or two padded blocks, compressed before the digest goes out in
// 8 or 6 transfers; the input is not ready throughout.
// Reset loads the SHA-512 initial value and clears the length and fill counts.
module sha512_sha384_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] msg_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_out,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import sha512_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_COMP, ST_FOLD, ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PAD_MARK, PAD_LEN, PAD_SKIP, PAD_DONE
	} pad_t;

	state_t     state_q;
	logic       mode_q;
	word_t      chain_q [8];
	logic [63:0] total_q;
	logic [3:0] fill_q;
	pad_t       pad_q;
	logic       after_pad_q;
	logic [2:0] oidx_q;
	logic       wr_en;
	logic [3:0] wr_idx;
	word_t      wr_data;
	logic       start;
	logic       done;
	word_t      work [8];
	rnd_ctl_t   rctl;
	logic       accept;
	logic [3:0] nv;
	logic [63:0] keep;
	word_t      pad_word;
	logic [63:0] new_total;
	logic [2:0] last_idx;

	sha512_round u_round (
		.clk(clk), .arst_n(arst_n), .start(start), .wr_en(wr_en), .wr_idx(wr_idx),
		.wr_data(wr_data), .chain(chain_q), .work(work), .ctl(rctl), .done(done)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign nv = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
	assign keep = (nv == 4'd0) ? 64'd0 : ~(64'hFFFFFFFFFFFFFFFF >> {nv, 3'b000});
	assign new_total = total_q + (last_word ? {60'd0, nv} : 64'd8);
	assign last_idx = mode_q ? 3'd5 : 3'd7;

	// Padding word for the current position: the marker byte, zeros or the two length words.
	always_comb begin
		pad_word = '0;
		if (pad_q == PAD_MARK) begin
			pad_word = 64'h8000000000000000;
		end else if (pad_q == PAD_LEN && fill_q == 4'd14) begin
			pad_word = {61'd0, total_q[63:61]};
		end else if (pad_q == PAD_LEN && fill_q == 4'd15) begin
			pad_word = {total_q[60:0], 3'b000};
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_idx = fill_q;
		wr_data = msg_word;
		if (accept) begin
			wr_en = 1'b1;
			if (last_word && nv != 4'd8) begin
				wr_data = (msg_word & keep) | (64'h8000000000000000 >> {nv, 3'b000});
			end
		end else if (state_q == ST_PAD) begin
			wr_en = 1'b1;
			wr_data = pad_word;
		end
	end

	assign start = wr_en && (fill_q == 4'd15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= 1'b0;
			total_q <= '0;
			fill_q <= '0;
			pad_q <= PAD_MARK;
			after_pad_q <= 1'b0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= iv_word(1'b0, 3'(i));
			end
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
				total_q <= '0;
				fill_q <= '0;
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= iv_word(cfg_wdata, 3'(i));
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						total_q <= new_total;
						fill_q <= fill_q + 4'd1;
						after_pad_q <= last_word;
						// A full final word still needs the marker word.
						if (nv == 4'd8) begin
							pad_q <= PAD_MARK;
						end else if (fill_q == 4'd14) begin
							pad_q <= PAD_SKIP;
						end else begin
							pad_q <= PAD_LEN;
						end
						if (start) begin
							state_q <= ST_COMP;
						end else if (last_word) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 4'd1;
					if (pad_q == PAD_MARK) begin
						pad_q <= (fill_q == 4'd14) ? PAD_SKIP : PAD_LEN;
					end else if (pad_q == PAD_SKIP && fill_q == 4'd15) begin
						pad_q <= PAD_LEN;
					end else if (pad_q == PAD_LEN && fill_q == 4'd15) begin
						pad_q <= PAD_DONE;
					end
					if (start) begin
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (done) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work[i];
					end
					if (!after_pad_q) begin
						state_q <= ST_IDLE;
					end else if (pad_q == PAD_DONE) begin
						state_q <= ST_OUT;
						oidx_q <= '0;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == last_idx) begin
							state_q <= ST_IDLE;
							total_q <= '0;
							fill_q <= '0;
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= iv_word(mode_q, 3'(i));
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign digest_word = chain_q[oidx_q];
	assign word_index = oidx_q;
	assign last_out = (oidx_q == last_idx);

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !rctl.busy) else $error("input taken during compression");
	a_out_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (word_index <= last_idx)) else $error("digest index out of range");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rctl.start |=> rctl.busy) else $error("round unit failed to start");
`endif
endmodule

>>> bench/sha512_sha384_hash_core_checker.sv
// Checker for the SHA-512 / SHA-384 hash core: watches the input, output and register ports.
// Predicts every digest word with its own model of the hash and compares; uses no package.
`timescale 1ns / 1ps
module sha512_sha384_hash_core_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [63:0] msg_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_out,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output int          fail_count,
	output int          digests_pending
);

	typedef struct {
		logic [63:0] word;
		logic [2:0]  index;
		logic        final_word;
	} digest_item_t;

	localparam logic [63:0] K [80] = '{
		64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
		64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
		64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
		64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
		64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
		64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
		64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
		64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
		64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
		64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
		64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
		64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
		64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
		64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
		64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
		64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
		64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
		64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
		64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
		64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
	};

	localparam logic [63:0] START_512 [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};
	localparam logic [63:0] START_384 [8] = '{
		64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17, 64'h152FECD8F70E5939,
		64'h67332667FFC00B31, 64'h8EB44A8768581511, 64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4
	};

	logic        mode_384;
	logic [63:0] chain [8];
	logic [63:0] sched [16];
	logic [63:0] byte_total;
	logic [3:0]  fill;
	digest_item_t digest_queue [$];

	assign digests_pending = digest_queue.size();

	function automatic logic [63:0] rot_right(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < 8; i++)
			chain[i] = mode_384 ? START_384[i] : START_512[i];
		byte_total = '0;
		fill = '0;
	endfunction

	function automatic void fold_block();
		logic [63:0] v [8];
		logic [63:0] x2, x15, t1, t2;
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int t = 0; t < 80; t++) begin
			if (t >= 16) begin
				x2 = sched[(t - 2) & 15];
				x15 = sched[(t - 15) & 15];
				sched[t & 15] += (rot_right(x2, 19) ^ rot_right(x2, 61) ^ (x2 >> 6))
					+ sched[(t - 7) & 15]
					+ (rot_right(x15, 1) ^ rot_right(x15, 8) ^ (x15 >> 7));
			end
			t1 = v[7] + (rot_right(v[4], 14) ^ rot_right(v[4], 18) ^ rot_right(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[t] + sched[t & 15];
			t2 = (rot_right(v[0], 28) ^ rot_right(v[0], 34) ^ rot_right(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endfunction

	function automatic void absorb_word(input logic [63:0] w);
		sched[fill] = w;
		fill = fill + 4'd1;
		if (fill == 4'd0)
			fold_block();
	endfunction

	function automatic void hash_word(input logic [63:0] w, input logic [3:0] nb, input logic fin);
		int count;
		int words;
		digest_item_t item;
		if (!fin) begin
			byte_total += 64'd8;
			absorb_word(w);
			return;
		end
		count = (nb > 4'd8) ? 8 : int'(nb);
		byte_total += 64'(count);
		if (count == 8) begin
			absorb_word(w);
			absorb_word(64'h80 << 56);
		end else begin
			absorb_word((w & ((count == 0) ? 64'd0 : ~64'd0 << (64 - 8 * count)))
				| (64'h80 << (56 - 8 * count)));
		end
		while (fill != 4'd14)
			absorb_word('0);
		absorb_word(byte_total >> 61);
		absorb_word(byte_total << 3);
		words = mode_384 ? 6 : 8;
		for (int k = 0; k < words; k++) begin
			item.word = chain[k];
			item.index = 3'(k);
			item.final_word = (k == words - 1);
			digest_queue.push_back(item);
		end
		restart_hash();
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		digest_item_t want;
		if (!arst_n) begin
			mode_384 = 1'b0;
			restart_hash();
			digest_queue.delete();
		end else begin
			if (cfg_we) begin
				mode_384 = cfg_wdata;
				restart_hash();
			end
			if (in_valid && in_ready)
				hash_word(msg_word, valid_bytes, last_word);
			if (out_valid && out_ready) begin
				if (digest_queue.size() == 0) begin
					report_mismatch("unexpected digest transfer", digest_word, '0);
				end else begin
					want = digest_queue.pop_front();
					if (digest_word !== want.word)
						report_mismatch("digest_word", digest_word, want.word);
					if (word_index !== want.index)
						report_mismatch("word_index", 64'(word_index), 64'(want.index));
					if (last_out !== want.final_word)
						report_mismatch("last_out", 64'(last_out), 64'(want.final_word));
				end
			end
		end
	end

endmodule

>>> bench/tb_sha512_sha384_hash_core.sv
// Testbench top for the SHA-512 / SHA-384 hash core: clock, reset, message and register stimulus.
// Depends on sha512_sha384_hash_core and sha512_sha384_hash_core_checker.
`timescale 1ns / 1ps
module tb_sha512_sha384_hash_core;

	localparam int CycleLimit = 400000;
	localparam int SettleCycles = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] msg_word;
	logic [3:0]  valid_bytes;
	logic        last_word;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        last_out;
	logic        cfg_we;
	logic        cfg_wdata;
	int          fail_count;
	int          digests_pending;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          words_sent;
	int          cycles;
	logic        long_hold_req;

	sha512_sha384_hash_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.msg_word(msg_word), .valid_bytes(valid_bytes), .last_word(last_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_out(last_out),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	sha512_sha384_hash_core_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.msg_word(msg_word), .valid_bytes(valid_bytes), .last_word(last_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_out(last_out),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .digests_pending(digests_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CycleLimit) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// The long hold is counted here so that the sender keeps offering words meanwhile.
	initial begin
		int hold_left;
		logic hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_done) begin
				hold_left = 2000;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_word(input logic [63:0] w, input logic [3:0] nb, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		msg_word <= w;
		valid_bytes <= nb;
		last_word <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (digests_pending != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] random_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_message(input int room);
		int len;
		len = ($urandom_range(99) < 85) ? $urandom_range(0, 20) : $urandom_range(21, 40);
		if (len > room - 1)
			len = room - 1;
		for (int i = 0; i < len; i++)
			send_word(random_word(), 4'($urandom_range(15)), 1'b0);
		send_word(random_word(), 4'($urandom_range(15)), 1'b1);
	endtask

	task automatic random_phase(input int target);
		int stop_at;
		stop_at = words_sent + target;
		while (words_sent < stop_at)
			random_message(stop_at - words_sent);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		msg_word = '0;
		valid_bytes = '0;
		last_word = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		words_sent = 0;
		long_hold_req = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word('0, 4'd0, 1'b1);
		send_word('1, 4'd8, 1'b1);
		send_word('1, 4'd15, 1'b1);
		send_word(64'h6162630000000000, 4'd3, 1'b1);
		send_word('1, 4'd1, 1'b1);
		for (int i = 0; i < 7; i++)
			send_word({$urandom, $urandom}, 4'(i + 9), 1'b0);
		send_word('1, 4'd7, 1'b1);
		write_mode(1'b1);
		send_word('0, 4'd0, 1'b1);
		send_word(64'h6162630000000000, 4'd3, 1'b1);
		// An unfinished message is dropped by the mode write that follows.
		for (int i = 0; i < 3; i++)
			send_word('1, 4'd8, 1'b0);
		write_mode(1'b0);
		send_word(64'h0123456789ABCDEF, 4'd8, 1'b1);

		send_idle_pct = 31;
		recv_idle_pct = 71;
		write_mode(1'b1);
		random_phase(50);
		send_idle_pct = 71;
		recv_idle_pct = 31;
		write_mode(1'b0);
		random_phase(50);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_mode(1'b1);
		long_hold_req = 1'b1;
		random_phase(50);
		settle();

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
